// ===== design/tcw_pkg.sv =====
// Shared constants, field widths and types for the text console writer.
// No dependencies; compile first.
`default_nettype none

package tcw_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int LAST_ROW_BASE = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;

    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = ATTR_W + CHAR_W;
    localparam int ADDR_W = 11;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Cursor move for one put request.
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              scroll;
        logic              store;
        logic [ADDR_W-1:0] pos;
    } cur_step_t;

endpackage

`default_nettype wire

// ===== design/tcw_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on tcw_pkg.
`default_nettype none

interface tcw_in_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;

    modport source (output valid, output operation, output char_code,
                    output cell_address, input ready);
    modport sink   (input valid, input operation, input char_code,
                    input cell_address, output ready);
endinterface

interface tcw_out_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_data;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;

    modport source (output valid, output cell_data, output cursor_column,
                    output cursor_row, output scrolled, input ready);
    modport sink   (input valid, input cell_data, input cursor_column,
                    input cursor_row, input scrolled, output ready);
endinterface

`default_nettype wire

// ===== design/text_console_writer_unit.sv =====
// Text console writer: screen store, cursor and scroll sequencer.
// A put goes from idle to the result state, a read through the read state first;
// a result waits in the output register until taken. A put that scrolls first
// copies the 1920 cells up one row and then blanks the bottom row (80 cells).
// After reset the store is swept to blank cells, one cell a cycle over all 2000
// cells; requests are held off meanwhile. One request is in work at a time.
// Depends on tcw_pkg, tcw_if and tcw_cursor.
`default_nettype none

module text_console_writer_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    tcw_in_if.sink                          request,
    tcw_out_if.source                       result,
    input  wire logic                       cfg_we,
    input  wire logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);
    import tcw_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_COPY   = 3'd3;
    localparam logic [2:0] ST_BLANK  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ATTR_W-1:0] attr_reg;
    logic              in_range_reg, in_range_next;
    logic [CELL_W-1:0] res_cell_reg, res_cell_next;
    logic              res_scroll_reg, res_scroll_next;
    logic              out_valid_reg, out_valid_next;
    logic [CELL_W-1:0] out_cell_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic              out_scroll_reg;

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] mem_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    logic              accept;
    logic              out_load;
    logic [ADDR_W-1:0] cnt_inc;
    cur_step_t         step;

    tcw_cursor u_cursor (
        .col       (col_reg),
        .row       (row_reg),
        .char_code (request.char_code),
        .step      (step)
    );

    assign request.ready = (state_reg == ST_IDLE);
    assign accept        = request.valid && request.ready;
    assign out_load      = (state_reg == ST_RESULT) && (!out_valid_reg || result.ready);
    assign cnt_inc       = cnt_reg + ADDR_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        in_range_next   = in_range_reg;
        res_cell_next   = res_cell_reg;
        res_scroll_next = res_scroll_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg;
        mem_wdata       = {attr_reg, BLANK_CODE};
        mem_raddr       = request.cell_address;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_ATTR, BLANK_CODE};
                cnt_next  = cnt_inc;
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && request.operation == OP_READ)
                begin
                    in_range_next = (request.cell_address < ADDR_W'(CELL_COUNT));
                    state_next    = ST_READ;
                end
                else if (accept)
                begin
                    mem_we          = step.store;
                    mem_waddr       = step.pos;
                    mem_wdata       = {attr_reg, request.char_code};
                    col_next        = step.col;
                    row_next        = step.row;
                    res_cell_next   = '0;
                    res_scroll_next = step.scroll;
                    cnt_next        = '0;
                    state_next      = step.scroll ? ST_COPY : ST_RESULT;
                end
            end
            ST_READ:
            begin
                res_cell_next   = in_range_reg ? mem_rdata_reg : '0;
                res_scroll_next = 1'b0;
                state_next      = ST_RESULT;
            end
            ST_COPY:
            begin
                // read one row ahead, write the cell read last cycle
                mem_raddr = cnt_reg + ADDR_W'(SCREEN_WIDTH);
                mem_we    = (cnt_reg != '0);
                mem_waddr = cnt_reg - ADDR_W'(1);
                mem_wdata = mem_rdata_reg;
                if (cnt_reg == ADDR_W'(LAST_ROW_BASE))
                begin
                    state_next = ST_BLANK;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            ST_BLANK:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_inc;
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= RESET_ATTR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_range_reg   <= in_range_next;
        res_cell_reg   <= res_cell_next;
        res_scroll_reg <= res_scroll_next;
        if (out_load)
        begin
            out_cell_reg   <= res_cell_reg;
            out_col_reg    <= col_reg;
            out_row_reg    <= row_reg;
            out_scroll_reg <= res_scroll_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    assign result.valid         = out_valid_reg;
    assign result.cell_data     = out_cell_reg;
    assign result.cursor_column = out_col_reg;
    assign result.cursor_row    = out_row_reg;
    assign result.scrolled      = out_scroll_reg;

    a_load_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result shown without a finished request");

    a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg < ROW_W'(SCREEN_HEIGHT)) && (col_reg < COL_W'(SCREEN_WIDTH)))
        else $error("cursor left the screen");

    a_idle_write_is_put: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == ST_IDLE) |-> (accept && request.operation == OP_PUT))
        else $error("store written while idle without a put");

    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_scroll_reg) |-> (out_row_reg == ROW_W'(SCREEN_HEIGHT - 1)))
        else $error("scroll result not on the last row");

endmodule

`default_nettype wire

// ===== design/tcw_cursor.sv =====
// Cursor advance for a put: next column and row, scroll flag, store address.
// Depends on tcw_pkg.
`default_nettype none

module tcw_cursor (
    input  wire logic [tcw_pkg::COL_W-1:0]  col,
    input  wire logic [tcw_pkg::ROW_W-1:0]  row,
    input  wire logic [tcw_pkg::CHAR_W-1:0] char_code,
    output tcw_pkg::cur_step_t              step
);
    import tcw_pkg::*;

    logic [COL_W-1:0] col_inc;
    logic [ROW_W-1:0] row_inc;
    logic             line_end;

    assign col_inc  = col + COL_W'(1);
    assign row_inc  = row + ROW_W'(1);
    assign line_end = (char_code == NEWLINE_CODE) || (col_inc >= COL_W'(SCREEN_WIDTH));

    always_comb
    begin
        step.store  = (char_code != NEWLINE_CODE);
        step.pos    = ADDR_W'(row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col);
        step.col    = line_end ? '0 : col_inc;
        step.scroll = line_end && (row_inc >= ROW_W'(SCREEN_HEIGHT));
        if (!line_end)
        begin
            step.row = row;
        end
        else if (step.scroll)
        begin
            step.row = ROW_W'(SCREEN_HEIGHT - 1);
        end
        else
        begin
            step.row = row_inc;
        end
    end

endmodule

`default_nettype wire
